// File: rtl/core/rcpf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the remote command to player frame block.
// No dependencies; used by rcpf_decode and remote_command_to_player_frame.
package rcpf_pkg;

  // Frame layout
  localparam logic [7:0] FRAME_START   = 8'h7E;
  localparam logic [7:0] FRAME_VERSION = 8'hFF;
  localparam logic [7:0] FRAME_LENGTH  = 8'h06;
  localparam logic [7:0] FRAME_NO_ACK  = 8'h00;
  localparam logic [7:0] FRAME_PAR_HI  = 8'h00;
  localparam logic [7:0] FRAME_END     = 8'hEF;

  // Byte positions within a frame
  localparam logic [3:0] POS_START   = 4'd0;
  localparam logic [3:0] POS_VERSION = 4'd1;
  localparam logic [3:0] POS_LENGTH  = 4'd2;
  localparam logic [3:0] POS_CMD     = 4'd3;
  localparam logic [3:0] POS_ACK     = 4'd4;
  localparam logic [3:0] POS_PAR_HI  = 4'd5;
  localparam logic [3:0] POS_PAR_LO  = 4'd6;
  localparam logic [3:0] POS_CHK_HI  = 4'd7;
  localparam logic [3:0] POS_CHK_LO  = 4'd8;
  localparam logic [3:0] POS_END     = 4'd9;

  // Player command codes
  localparam logic [7:0] CMD_NEXT     = 8'h01;
  localparam logic [7:0] CMD_VOL_UP   = 8'h04;
  localparam logic [7:0] CMD_VOL_DOWN = 8'h05;
  localparam logic [7:0] CMD_PLAY     = 8'h0D;
  localparam logic [7:0] CMD_PAUSE    = 8'h0E;
  localparam logic [7:0] CMD_TRACK    = 8'h12;

  // Remote characters
  localparam logic [7:0] CHR_NEXT     = 8'h4E; // 'N'
  localparam logic [7:0] CHR_VOL_UP   = 8'h55; // 'U'
  localparam logic [7:0] CHR_VOL_DOWN = 8'h4C; // 'L'
  localparam logic [7:0] CHR_PAUSE    = 8'h50; // 'P'
  localparam logic [7:0] CHR_MODE0    = 8'h44; // 'D'
  localparam logic [7:0] CHR_MODE1    = 8'h45; // 'E'
  localparam logic [7:0] CHR_MODE2    = 8'h46; // 'F'
  localparam logic [7:0] CHR_MODE3    = 8'h47; // 'G'
  localparam logic [7:0] CHR_DIGIT0   = 8'h30; // '0'
  localparam logic [7:0] CHR_DIGIT9   = 8'h39; // '9'
  localparam logic [7:0] TRACK_BIAS   = 8'h2F; // '0' maps to track 1

  // What one received character turns into
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cmd;
    logic [7:0]  param_lo;
    logic [15:0] chk;
    logic        toggle_pause;
    logic        set_mode;
    logic [1:0]  new_mode;
  } rcpf_dec_t;

endpackage

// File: rtl/core/rcpf_decode.sv
`timescale 1ns / 1ps
// Character decoder: maps one remote character to a frame command and checksum.
// Depends on rcpf_pkg.
module rcpf_decode (
  input  logic [7:0]         rx_byte,
  input  logic               paused,
  output rcpf_pkg::rcpf_dec_t dec
);
  import rcpf_pkg::*;

  logic [15:0] sum;

  always_comb begin
    dec              = '0;
    dec.kind         = KIND_FRAME;
    dec.param_lo     = 8'h00;
    case (rx_byte)
      CHR_NEXT:     dec.cmd = CMD_NEXT;
      CHR_VOL_UP:   dec.cmd = CMD_VOL_UP;
      CHR_VOL_DOWN: dec.cmd = CMD_VOL_DOWN;
      CHR_PAUSE: begin
        dec.cmd          = paused ? CMD_PLAY : CMD_PAUSE;
        dec.toggle_pause = 1'b1;
      end
      CHR_MODE0, CHR_MODE1, CHR_MODE2, CHR_MODE3: begin
        dec.kind     = KIND_STATUS;
        dec.set_mode = 1'b1;
        dec.new_mode = rx_byte[1:0] ^ CHR_MODE0[1:0];
      end
      default: begin
        if (rx_byte >= CHR_DIGIT0 && rx_byte <= CHR_DIGIT9) begin
          dec.cmd      = CMD_TRACK;
          dec.param_lo = rx_byte - TRACK_BIAS;
        end else begin
          dec.kind = KIND_NONE;
        end
      end
    endcase
    // checksum covers version through parameter low
    sum = {8'h00, FRAME_VERSION} + {8'h00, FRAME_LENGTH} + {8'h00, dec.cmd}
        + {8'h00, FRAME_NO_ACK} + {8'h00, FRAME_PAR_HI} + {8'h00, dec.param_lo};
    dec.chk = 16'h0000 - sum;
  end

endmodule

// File: rtl/core/remote_command_to_player_frame.sv
`timescale 1ns / 1ps
// Top level: remote character in, serial player command frame bytes out.
// Depends on rcpf_pkg and rcpf_decode.

// Each accepted character is decoded at once into a command register; the
// pause flag and swing mode update at that moment. Play, pause, volume, next
// and digit characters yield ten frame items (tuser 1, tlast on the tenth),
// mode characters D to G yield one status item (tuser 0, tx byte 0, tlast 1),
// and anything else yields nothing. One item leaves per cycle while the
// receiver is ready, through a registered output; a new character is taken in
// the cycle its predecessor's last item moves to the output register, so
// characters run back to back with no gap. A character passes through the
// command register and then the output register before its first item
// appears.
module remote_command_to_player_frame (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [9:8] swing_mode, [15:10] zero
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast   // last
);
  import rcpf_pkg::*;

  rcpf_dec_t dec;

  // control state
  logic       paused_r, paused_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic       ovalid_r, ovalid_nxt;

  // command register payload
  logic        frame_r;
  logic [7:0]  cmd_r;
  logic [7:0]  par_r;
  logic [15:0] chk_r;
  logic [1:0]  imode_r;

  // output register payload
  logic [7:0] obyte_r;
  logic       obv_r;
  logic       olast_r;
  logic [1:0] omode_r;

  logic       out_free, emit, item_last, in_acc;
  logic [7:0] byte_sel;

  rcpf_decode u_decode (
    .rx_byte (in_tdata),
    .paused  (paused_r),
    .dec     (dec)
  );

  // handshake
  assign out_free  = !ovalid_r || out_tready;
  assign emit      = busy_r && out_free;
  assign item_last = !frame_r || (pos_r == POS_END);
  assign in_tready = !busy_r || (emit && item_last);
  assign in_acc    = in_tvalid && in_tready;

  // frame byte select
  always_comb begin
    case (pos_r)
      POS_START:   byte_sel = FRAME_START;
      POS_VERSION: byte_sel = FRAME_VERSION;
      POS_LENGTH:  byte_sel = FRAME_LENGTH;
      POS_CMD:     byte_sel = cmd_r;
      POS_ACK:     byte_sel = FRAME_NO_ACK;
      POS_PAR_HI:  byte_sel = FRAME_PAR_HI;
      POS_PAR_LO:  byte_sel = par_r;
      POS_CHK_HI:  byte_sel = chk_r[15:8];
      POS_CHK_LO:  byte_sel = chk_r[7:0];
      POS_END:     byte_sel = FRAME_END;
      default:     byte_sel = FRAME_END;
    endcase
  end

  // next-state logic
  always_comb begin
    paused_nxt = paused_r;
    mode_nxt   = mode_r;
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      pos_nxt    = pos_r + 4'd1;
      if (item_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = (dec.kind != KIND_NONE);
      pos_nxt  = POS_START;
      if (dec.toggle_pause) begin
        paused_nxt = !paused_r;
      end
      if (dec.set_mode) begin
        mode_nxt = dec.new_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
      mode_r   <= 2'd0;
      busy_r   <= 1'b0;
      pos_r    <= POS_START;
      ovalid_r <= 1'b0;
    end else begin
      paused_r <= paused_nxt;
      mode_r   <= mode_nxt;
      busy_r   <= busy_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // command register load
  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame_r <= (dec.kind == KIND_FRAME);
      cmd_r   <= dec.cmd;
      par_r   <= dec.param_lo;
      chk_r   <= dec.chk;
      imode_r <= dec.set_mode ? dec.new_mode : mode_r;
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r <= frame_r ? byte_sel : 8'h00;
      obv_r   <= frame_r;
      olast_r <= item_last;
      omode_r <= imode_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'b000000, omode_r, obyte_r};
  assign out_tuser  = obv_r;
  assign out_tlast  = olast_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for remote_command_to_player_frame: feeds remote characters,
// predicts the player frame or status items and compares every output item.
// Depends on rcpf_pkg and the RTL top level only.
module tb_top;
  import rcpf_pkg::*;

  // One output item as the bench expects it
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] swing_mode;
  } player_item_t;

  // Directed opening: every command, both pause states, digit ends, modes, field extremes
  localparam logic [7:0] DIRECTED_CHARS [24] = '{
    CHR_NEXT, CHR_VOL_UP, CHR_VOL_DOWN, CHR_PAUSE, CHR_PAUSE, CHR_PAUSE,
    CHR_DIGIT0, CHR_DIGIT9, CHR_MODE1, CHR_NEXT, CHR_MODE2, CHR_MODE3,
    CHR_DIGIT0 + 8'd4, CHR_MODE0, 8'h00, 8'hFF, CHR_DIGIT0 - 8'd1,
    CHR_DIGIT9 + 8'd1, CHR_MODE0 - 8'd1, CHR_MODE3 + 8'd1, 8'h7F, 8'h80,
    CHR_VOL_DOWN, CHR_MODE0
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] tx_byte, [9:8] swing_mode, [15:10] zero
  logic        out_tuser;          // [0] byte_valid
  logic        out_tlast;

  logic [7:0]   rx_pending[$];     // characters still to be sent
  player_item_t frame_q[$];        // items the block still owes
  logic         pause_flag;        // predicted playing/paused flag
  logic [1:0]   swing_reg;         // predicted swing mode
  logic         calm = 1'b0;       // no idling on either side
  logic [31:0]  cycle_no = '0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           errors = 0;

  remote_command_to_player_frame u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Push the ten bytes of one player frame
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] param_lo);
    logic [7:0]  body[10];
    logic [15:0] sum;
    logic [15:0] chk;
    player_item_t it;
    sum = 16'(FRAME_VERSION) + 16'(FRAME_LENGTH) + 16'(cmd) + 16'(FRAME_NO_ACK)
          + 16'(FRAME_PAR_HI) + 16'(param_lo);
    chk = 16'(0) - sum;
    body[POS_START]   = FRAME_START;
    body[POS_VERSION] = FRAME_VERSION;
    body[POS_LENGTH]  = FRAME_LENGTH;
    body[POS_CMD]     = cmd;
    body[POS_ACK]     = FRAME_NO_ACK;
    body[POS_PAR_HI]  = FRAME_PAR_HI;
    body[POS_PAR_LO]  = param_lo;
    body[POS_CHK_HI]  = chk[15:8];
    body[POS_CHK_LO]  = chk[7:0];
    body[POS_END]     = FRAME_END;
    for (int k = 0; k < 10; k++) begin
      it.tx_byte    = body[k];
      it.byte_valid = 1'b1;
      it.last       = (k == int'(POS_END));
      it.swing_mode = swing_reg;
      frame_q.push_back(it);
    end
  endtask

  // Predicted effect of one accepted character
  task automatic expand_command(input logic [7:0] c);
    player_item_t it;
    if (c == CHR_NEXT) begin
      queue_frame(CMD_NEXT, 8'h00);
    end else if (c == CHR_VOL_UP) begin
      queue_frame(CMD_VOL_UP, 8'h00);
    end else if (c == CHR_VOL_DOWN) begin
      queue_frame(CMD_VOL_DOWN, 8'h00);
    end else if (c == CHR_PAUSE) begin
      queue_frame(pause_flag ? CMD_PLAY : CMD_PAUSE, 8'h00);
      pause_flag = !pause_flag;
    end else if (c >= CHR_MODE0 && c <= CHR_MODE3) begin
      swing_reg     = 2'(c - CHR_MODE0);
      it.tx_byte    = 8'h00;
      it.byte_valid = 1'b0;
      it.last       = 1'b1;
      it.swing_mode = swing_reg;
      frame_q.push_back(it);
    end else if (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) begin
      queue_frame(CMD_TRACK, c - TRACK_BIAS);
    end
  endtask

  function automatic bit is_command(input logic [7:0] c);
    return c == CHR_NEXT || c == CHR_VOL_UP || c == CHR_VOL_DOWN || c == CHR_PAUSE
           || (c >= CHR_MODE0 && c <= CHR_MODE3) || (c >= CHR_DIGIT0 && c <= CHR_DIGIT9);
  endfunction

  // Mostly real commands, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CHR_NEXT;
    if (r < 20) return CHR_VOL_UP;
    if (r < 30) return CHR_VOL_DOWN;
    if (r < 45) return CHR_PAUSE;
    if (r < 65) return CHR_DIGIT0 + 8'($urandom_range(0, 9));
    if (r < 80) return CHR_MODE0 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue random characters until n of them are real commands
  task automatic load_random(input int n);
    logic [7:0] c;
    int got;
    got = 0;
    while (got < n) begin
      c = pick_char();
      rx_pending.push_back(c);
      if (is_command(c)) got++;
    end
  endtask

  // Wait at falling edges until everything sent has come back
  task automatic drain();
    while (rx_pending.size() != 0 || in_tvalid || frame_q.size() != 0) @(negedge clk);
  endtask

  // Character driver with bursty gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && cycle_no[6] && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_pending.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && !calm && cycle_no[8:7] != 2'd0 && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Prediction on accepted characters, check on accepted output items
  always @(posedge clk) begin : monitor
    player_item_t want;
    if (!rst_n) begin
      pause_flag = 1'b0;
      swing_reg  = 2'd0;
    end else begin
      if (in_tvalid && in_tready) expand_command(in_tdata);
      if (out_tvalid && out_tready) begin
        if (frame_q.size() == 0) begin
          flag_mismatch("unexpected item", out_tdata, 0);
        end else begin
          want = frame_q.pop_front();
          if (out_tdata[7:0] !== want.tx_byte)
            flag_mismatch("tx_byte", out_tdata[7:0], want.tx_byte);
          if (out_tdata[9:8] !== want.swing_mode)
            flag_mismatch("swing_mode", out_tdata[9:8], want.swing_mode);
          if (out_tdata[15:10] !== 6'd0)
            flag_mismatch("tdata pad", out_tdata[15:10], 0);
          if (out_tuser !== want.byte_valid)
            flag_mismatch("byte_valid", out_tuser, want.byte_valid);
          if (out_tlast !== want.last)
            flag_mismatch("last", out_tlast, want.last);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_CHARS[i])
      rx_pending.push_back(DIRECTED_CHARS[i]);
    drain();

    // Random traffic, with full drains in between
    load_random(100);
    drain();
    load_random(75);
    drain();

    // Final stretch with no gaps or stalls
    calm = 1'b1;
    load_random(30);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && frame_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
